### hw/rtl/mee_pkg.sv
// mee_pkg: shared types and constants of the modular exponentiation engine
// no dependencies; used by mee_word_alu and modular_exponentiation_engine_core
package mee_pkg;

    localparam int WORD_BITS = 64;
    localparam int OPERAND_BITS = 2048;
    localparam int WORDS = (OPERAND_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W = $clog2(WORDS);
    localparam int CNT_W = ADDR_W + 1;
    localparam int BIT_W = $clog2(WORD_BITS);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_AREAD,
        S_ALATCH,
        S_PASS,
        S_COPY,
        S_EREAD,
        S_ELATCH,
        S_EBIT,
        S_OUT
    } t_state;

    // operation carried out by the shared multiply/reduce passes
    typedef enum logic [1:0] {
        OP_ONE,
        OP_RED,
        OP_MUL,
        OP_SQR
    } t_op;

    // result candidate selects
    localparam logic [1:0] SEL_T = 2'd0;
    localparam logic [1:0] SEL_TM = 2'd1;
    localparam logic [1:0] SEL_T2M = 2'd2;

endpackage

### hw/rtl/modular_exponentiation_engine_core.sv
// modular_exponentiation_engine_core: right-to-left binary modular exponentiation, word serial
// depends on mee_pkg and mee_word_alu
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------------
//  operand  | start / busy            | i_base_word, i_exponent_word, i_modulus_word,
//           |                         | i_last_word
//  result   | o_result_valid (strobe) | o_result_word, o_result_last, o_error_flag
//
// a non-last item is taken while busy stays low; the last item starts the run and busy stays high
// until the last result word leaves. each modular multiply scans n*64 bits of one operand,
// and each bit is one pass through the word slice adder (n = words loaded),
// followed by a copy of the chosen candidate to its destination.
// results leave at one word a cycle and cannot be stalled. reset is synchronous, active low.
module modular_exponentiation_engine_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mee_pkg::WORD_BITS-1:0] i_base_word,
    input  logic [mee_pkg::WORD_BITS-1:0] i_exponent_word,
    input  logic [mee_pkg::WORD_BITS-1:0] i_modulus_word,
    input  logic                          i_last_word,
    output logic                          o_result_valid,
    output logic [mee_pkg::WORD_BITS-1:0] o_result_word,
    output logic                          o_result_last,
    output logic                          o_error_flag
);
    localparam int W = mee_pkg::WORD_BITS;
    localparam int AW = mee_pkg::ADDR_W;
    localparam int CW = mee_pkg::CNT_W;
    localparam int BW = mee_pkg::BIT_W;
    localparam int N = mee_pkg::WORDS;

    // operand memories
    logic [W-1:0] m_x  [N];
    logic [W-1:0] m_y  [N];
    logic [W-1:0] m_e  [N];
    logic [W-1:0] m_m  [N];
    logic [W-1:0] m_p0 [N];
    logic [W-1:0] m_p1 [N];
    logic [W-1:0] m_p2 [N];

    logic [W-1:0] r_xq, r_yq, r_eq, r_mq, r_p0q, r_p1q, r_p2q;

    mee_pkg::t_state r_state, n_state;
    mee_pkg::t_op    r_op, n_op;

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_mnz, n_mnz;
    logic [CW-1:0] r_n, n_n;
    logic          r_err, n_err;
    logic [CW-1:0] r_k, n_k;
    logic          r_dv, n_dv;
    logic [CW-1:0] r_dk, n_dk;
    logic [AW-1:0] r_awrd, n_awrd;
    logic [BW-1:0] r_abit, n_abit;
    logic [W-1:0]  r_ash, n_ash;
    logic [CW-1:0] r_ewrd, n_ewrd;
    logic [BW-1:0] r_ebit, n_ebit;
    logic [W-1:0]  r_esh, n_esh;
    logic          r_rzero, n_rzero;
    logic [1:0]    r_sel, n_sel;
    logic          r_ct, n_ct;
    logic          r_rsh, n_rsh;
    logic          r_b1, n_b1;
    logic          r_b2, n_b2;
    logic          r_msh, n_msh;
    logic          r_ov, n_ov;
    logic [W-1:0]  r_ow, n_ow;
    logic          r_ol, n_ol;
    logic          r_oe, n_oe;

    // memory write controls
    logic          ld_we;
    logic [AW-1:0] ld_wa;
    logic          x_we, y_we, p_we;
    logic [AW-1:0] cp_wa;
    logic [AW-1:0] rd_addr;

    // word slice signals
    logic [W-1:0] alu_r, alu_b, alu_m, alu_t, alu_d1, alu_d2, p_sel_q;
    logic         alu_rsh, alu_cin, alu_msh, alu_b1, alu_b2;
    logic         alu_cout, alu_bo1, alu_bo2;
    logic         a_bit, top_word;

    assign busy = (r_state != mee_pkg::S_IDLE);
    assign o_result_valid = r_ov;
    assign o_result_word = r_ow;
    assign o_result_last = r_ol;
    assign o_error_flag = r_oe;

    // candidate chosen by the previous pass
    always_comb begin
        case (r_sel)
            mee_pkg::SEL_TM:  p_sel_q = r_p1q;
            mee_pkg::SEL_T2M: p_sel_q = r_p2q;
            default:          p_sel_q = r_p0q;
        endcase
    end

    // word slice operands; the word above the loaded ones reads as zero
    assign a_bit = r_ash[W-1];
    assign top_word = (r_dk == r_n);
    assign alu_r = (r_rzero || top_word) ? '0 : p_sel_q;
    assign alu_b = (top_word || !a_bit || r_op == mee_pkg::OP_ONE || r_op == mee_pkg::OP_RED)
                   ? '0 : r_xq;
    assign alu_m = top_word ? '0 : r_mq;
    assign alu_rsh = (r_dk == '0) ? 1'b0 : r_rsh;
    assign alu_msh = (r_dk == '0) ? 1'b0 : r_msh;
    assign alu_b1 = (r_dk == '0) ? 1'b0 : r_b1;
    assign alu_b2 = (r_dk == '0) ? 1'b0 : r_b2;
    assign alu_cin = (r_dk == '0)
                     ? (a_bit && (r_op == mee_pkg::OP_ONE || r_op == mee_pkg::OP_RED))
                     : r_ct;

    mee_word_alu u_alu (
        .i_r    (alu_r),
        .i_rsh  (alu_rsh),
        .i_b    (alu_b),
        .i_cin  (alu_cin),
        .i_m    (alu_m),
        .i_msh  (alu_msh),
        .i_b1   (alu_b1),
        .i_b2   (alu_b2),
        .o_t    (alu_t),
        .o_cout (alu_cout),
        .o_d1   (alu_d1),
        .o_bo1  (alu_bo1),
        .o_d2   (alu_d2),
        .o_bo2  (alu_bo2)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mee_pkg::S_IDLE;
            r_cnt   <= '0;
            r_mnz   <= 1'b0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_mnz   <= n_mnz;
            r_dv    <= n_dv;
            r_ov    <= n_ov;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_n     <= n_n;
        r_err   <= n_err;
        r_k     <= n_k;
        r_dk    <= n_dk;
        r_awrd  <= n_awrd;
        r_abit  <= n_abit;
        r_ash   <= n_ash;
        r_ewrd  <= n_ewrd;
        r_ebit  <= n_ebit;
        r_esh   <= n_esh;
        r_rzero <= n_rzero;
        r_sel   <= n_sel;
        r_ct    <= n_ct;
        r_rsh   <= n_rsh;
        r_b1    <= n_b1;
        r_b2    <= n_b2;
        r_msh   <= n_msh;
        r_ow    <= n_ow;
        r_ol    <= n_ol;
        r_oe    <= n_oe;
    end

    // memories: registered reads at one shared address, writes from load, pass and copy
    always_ff @(posedge i_clk) begin
        r_xq  <= m_x[rd_addr];
        r_yq  <= m_y[rd_addr];
        r_eq  <= m_e[rd_addr];
        r_mq  <= m_m[rd_addr];
        r_p0q <= m_p0[rd_addr];
        r_p1q <= m_p1[rd_addr];
        r_p2q <= m_p2[rd_addr];
        if (ld_we) begin
            m_x[ld_wa] <= i_base_word;
            m_e[ld_wa] <= i_exponent_word;
            m_m[ld_wa] <= i_modulus_word;
        end else if (x_we) begin
            m_x[cp_wa] <= p_sel_q;
        end
        if (y_we) begin
            m_y[cp_wa] <= p_sel_q;
        end
        if (p_we) begin
            m_p0[cp_wa] <= alu_t;
            m_p1[cp_wa] <= alu_d1;
            m_p2[cp_wa] <= alu_d2;
        end
    end

    // next state and controls
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_mnz   = r_mnz;
        n_n     = r_n;
        n_err   = r_err;
        n_k     = r_k;
        n_dv    = 1'b0;
        n_dk    = r_k;
        n_awrd  = r_awrd;
        n_abit  = r_abit;
        n_ash   = r_ash;
        n_ewrd  = r_ewrd;
        n_ebit  = r_ebit;
        n_esh   = r_esh;
        n_rzero = r_rzero;
        n_sel   = r_sel;
        n_ct    = r_ct;
        n_rsh   = r_rsh;
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_msh   = r_msh;
        n_ov    = 1'b0;
        n_ow    = r_ow;
        n_ol    = 1'b0;
        n_oe    = r_oe;
        ld_we   = 1'b0;
        ld_wa   = r_cnt[AW-1:0];
        x_we    = 1'b0;
        y_we    = 1'b0;
        p_we    = 1'b0;
        cp_wa   = r_dk[AW-1:0];
        rd_addr = r_k[AW-1:0];

        unique case (r_state)
            // operand load
            mee_pkg::S_IDLE: begin
                if (start) begin
                    if (!r_cnt[CW-1]) begin
                        ld_we = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                        n_mnz = r_mnz | (i_modulus_word != '0);
                    end
                    if (i_last_word) begin
                        n_n   = n_cnt;
                        n_cnt = '0;
                        n_mnz = 1'b0;
                        n_k   = '0;
                        if (!(r_mnz | ((i_modulus_word != '0) && !r_cnt[CW-1]))) begin
                            n_err   = 1'b1;
                            n_state = mee_pkg::S_OUT;
                        end else begin
                            n_err   = 1'b0;
                            n_op    = mee_pkg::OP_ONE;
                            n_state = mee_pkg::S_SETUP;
                        end
                    end
                end
            end

            // begin a multiply or reduction, accumulator cleared
            mee_pkg::S_SETUP: begin
                n_rzero = 1'b1;
                n_k     = '0;
                if (r_op == mee_pkg::OP_ONE) begin
                    n_ash   = {1'b1, {(W-1){1'b0}}};
                    n_abit  = BW'(W - 1);
                    n_awrd  = '0;
                    n_state = mee_pkg::S_PASS;
                end else begin
                    n_awrd  = AW'(r_n - CW'(1));
                    n_abit  = '0;
                    n_state = mee_pkg::S_AREAD;
                end
            end

            mee_pkg::S_AREAD: begin
                rd_addr = r_awrd;
                n_state = mee_pkg::S_ALATCH;
            end

            mee_pkg::S_ALATCH: begin
                n_ash   = (r_op == mee_pkg::OP_MUL) ? r_yq : r_xq;
                n_k     = '0;
                n_state = mee_pkg::S_PASS;
            end

            // one bit of the scanned operand: n+1 words through the slice
            mee_pkg::S_PASS: begin
                if (r_k <= r_n) begin
                    n_dv = 1'b1;
                    n_k  = r_k + CW'(1);
                end
                if (r_dv) begin
                    n_ct  = alu_cout;
                    n_rsh = alu_r[W-1];
                    n_msh = alu_m[W-1];
                    n_b1  = alu_bo1;
                    n_b2  = alu_bo2;
                    if (!top_word) begin
                        p_we = 1'b1;
                    end else begin
                        n_sel   = !alu_bo2 ? mee_pkg::SEL_T2M
                                : !alu_bo1 ? mee_pkg::SEL_TM : mee_pkg::SEL_T;
                        n_rzero = 1'b0;
                        n_ash   = {r_ash[W-2:0], 1'b0};
                        n_k     = '0;
                        if (r_abit == BW'(W - 1)) begin
                            if (r_awrd == '0) begin
                                n_state = mee_pkg::S_COPY;
                            end else begin
                                n_awrd  = r_awrd - AW'(1);
                                n_abit  = '0;
                                n_state = mee_pkg::S_AREAD;
                            end
                        end else begin
                            n_abit = r_abit + BW'(1);
                        end
                    end
                end
            end

            // move the chosen candidate to its destination
            mee_pkg::S_COPY: begin
                if (r_k < r_n) begin
                    n_dv = 1'b1;
                    n_k  = r_k + CW'(1);
                end
                if (r_dv) begin
                    if (r_op == mee_pkg::OP_ONE || r_op == mee_pkg::OP_MUL) begin
                        y_we = 1'b1;
                    end else begin
                        x_we = 1'b1;
                    end
                    if (r_dk == r_n - CW'(1)) begin
                        case (r_op)
                            mee_pkg::OP_ONE: begin
                                n_op    = mee_pkg::OP_RED;
                                n_state = mee_pkg::S_SETUP;
                            end
                            mee_pkg::OP_RED: begin
                                n_ewrd  = '0;
                                n_state = mee_pkg::S_EREAD;
                            end
                            mee_pkg::OP_MUL: begin
                                n_op    = mee_pkg::OP_SQR;
                                n_state = mee_pkg::S_SETUP;
                            end
                            default: begin
                                n_esh = {1'b0, r_esh[W-1:1]};
                                if (r_ebit == BW'(W - 1)) begin
                                    if (r_ewrd == r_n - CW'(1)) begin
                                        n_k     = '0;
                                        n_state = mee_pkg::S_OUT;
                                    end else begin
                                        n_ewrd  = r_ewrd + CW'(1);
                                        n_state = mee_pkg::S_EREAD;
                                    end
                                end else begin
                                    n_ebit  = r_ebit + BW'(1);
                                    n_state = mee_pkg::S_EBIT;
                                end
                            end
                        endcase
                    end
                end
            end

            // exponent word fetch
            mee_pkg::S_EREAD: begin
                rd_addr = r_ewrd[AW-1:0];
                n_state = mee_pkg::S_ELATCH;
            end

            mee_pkg::S_ELATCH: begin
                n_esh   = r_eq;
                n_ebit  = '0;
                n_state = mee_pkg::S_EBIT;
            end

            // set bit multiplies first, every bit squares
            mee_pkg::S_EBIT: begin
                n_op    = r_esh[0] ? mee_pkg::OP_MUL : mee_pkg::OP_SQR;
                n_state = mee_pkg::S_SETUP;
            end

            // result words out
            mee_pkg::S_OUT: begin
                if (r_k < r_n) begin
                    n_dv = 1'b1;
                    n_k  = r_k + CW'(1);
                end
                if (r_dv) begin
                    n_ov = 1'b1;
                    n_ow = r_err ? '0 : r_yq;
                    n_ol = (r_dk == r_n - CW'(1));
                    n_oe = r_err;
                    if (r_dk == r_n - CW'(1)) begin
                        n_state = mee_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = mee_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_last |-> o_result_valid)
        else $error("result_last without strobe");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_error_flag) |-> (o_result_word == '0))
        else $error("error item carries nonzero word");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_last) |-> !busy)
        else $error("still busy after final item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(N))
        else $error("load count overflow");

endmodule

### hw/rtl/mee_word_alu.sv
// mee_word_alu: one word slice of a step 2R + B + c, with trial subtractions of M and 2M
// depends on mee_pkg
module mee_word_alu (
    input  logic [mee_pkg::WORD_BITS-1:0] i_r,
    input  logic                          i_rsh,
    input  logic [mee_pkg::WORD_BITS-1:0] i_b,
    input  logic                          i_cin,
    input  logic [mee_pkg::WORD_BITS-1:0] i_m,
    input  logic                          i_msh,
    input  logic                          i_b1,
    input  logic                          i_b2,
    output logic [mee_pkg::WORD_BITS-1:0] o_t,
    output logic                          o_cout,
    output logic [mee_pkg::WORD_BITS-1:0] o_d1,
    output logic                          o_bo1,
    output logic [mee_pkg::WORD_BITS-1:0] o_d2,
    output logic                          o_bo2
);
    localparam int W = mee_pkg::WORD_BITS;

    logic [W:0]   sum_t;
    logic [W:0]   sum_d1;
    logic [W:0]   sum_d2;
    logic [W-1:0] m2;

    // doubled accumulator word plus addend
    assign sum_t = {1'b0, i_r[W-2:0], i_rsh} + {1'b0, i_b} + {{W{1'b0}}, i_cin};
    assign o_t = sum_t[W-1:0];
    assign o_cout = sum_t[W];

    // trial subtraction of the modulus
    assign sum_d1 = {1'b0, sum_t[W-1:0]} - {1'b0, i_m} - {{W{1'b0}}, i_b1};
    assign o_d1 = sum_d1[W-1:0];
    assign o_bo1 = sum_d1[W];

    // trial subtraction of twice the modulus
    assign m2 = {i_m[W-2:0], i_msh};
    assign sum_d2 = {1'b0, sum_t[W-1:0]} - {1'b0, m2} - {{W{1'b0}}, i_b2};
    assign o_d2 = sum_d2[W-1:0];
    assign o_bo2 = sum_d2[W];

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for modular_exponentiation_engine_core
// depends on mee_pkg and the engine rtl; predicts each result word with wide integer math

// one expected result word
typedef struct {
    logic [mee_pkg::WORD_BITS-1:0] word;
    logic                          last;
    logic                          err;
} t_modexp_word;

// operand stores, power predictor and expected word queue
class t_modexp_scoreboard;
    localparam int NW = mee_pkg::WORDS;
    localparam int WIDE = 2 * mee_pkg::OPERAND_BITS;

    logic [63:0] base_words[NW];
    logic [63:0] exp_words[NW];
    logic [63:0] mod_words[NW];
    int held;
    t_modexp_word pending[$];
    int mismatches;
    int ops_done;
    int words_checked;
    int error_ops;

    function new();
        held = 0;
        mismatches = 0;
        ops_done = 0;
        words_checked = 0;
        error_ops = 0;
    endfunction

    // store one accepted operand item, and on the last one compute the power
    function void note_item(logic [63:0] b, logic [63:0] e, logic [63:0] m, logic last);
        logic [WIDE-1:0] bb, ee, mm, acc;
        t_modexp_word w;
        int n;
        logic err;
        if (held < NW) begin
            base_words[held] = b;
            exp_words[held] = e;
            mod_words[held] = m;
            held++;
        end
        if (!last)
            return;
        n = held;
        held = 0;
        bb = '0;
        ee = '0;
        mm = '0;
        for (int i = 0; i < n; i++) begin
            bb[i*64 +: 64] = base_words[i];
            ee[i*64 +: 64] = exp_words[i];
            mm[i*64 +: 64] = mod_words[i];
        end
        err = (mm == '0);
        acc = '0;
        if (!err) begin
            acc = WIDE'(1) % mm;
            bb = bb % mm;
            // right-to-left square and multiply
            for (int i = 0; i < n * 64; i++) begin
                if (ee[i])
                    acc = (acc * bb) % mm;
                bb = (bb * bb) % mm;
            end
        end
        ops_done++;
        if (err)
            error_ops++;
        for (int i = 0; i < n; i++) begin
            w.word = err ? 64'd0 : acc[i*64 +: 64];
            w.last = (i == n - 1);
            w.err = err;
            pending.push_back(w);
        end
    endfunction

    // compare one result word with the oldest expectation
    function void check_word(logic [63:0] word, logic last, logic err);
        t_modexp_word w;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result word %h last %b err %b", $time, word, last, err);
            mismatches++;
            return;
        end
        w = pending.pop_front();
        words_checked++;
        if (word !== w.word) begin
            $display("%0t: result word expected %h actual %h", $time, w.word, word);
            mismatches++;
        end
        if (last !== w.last) begin
            $display("%0t: last flag expected %b actual %b", $time, w.last, last);
            mismatches++;
        end
        if (err !== w.err) begin
            $display("%0t: error flag expected %b actual %b", $time, w.err, err);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [mee_pkg::WORD_BITS-1:0] i_base_word;
    logic [mee_pkg::WORD_BITS-1:0] i_exponent_word;
    logic [mee_pkg::WORD_BITS-1:0] i_modulus_word;
    logic                          i_last_word;
    logic                          o_result_valid;
    logic [mee_pkg::WORD_BITS-1:0] o_result_word;
    logic                          o_result_last;
    logic                          o_error_flag;

    t_modexp_scoreboard sb;
    bit gaps_on;
    int items_sent;

    modular_exponentiation_engine_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_base_word(i_base_word),
        .i_exponent_word(i_exponent_word),
        .i_modulus_word(i_modulus_word),
        .i_last_word(i_last_word),
        .o_result_valid(o_result_valid),
        .o_result_word(o_result_word),
        .o_result_last(o_result_last),
        .o_error_flag(o_error_flag)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #480_000_000;
        $display("FAILURE");
        $finish;
    end

    // accepted operand items feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_item(i_base_word, i_exponent_word, i_modulus_word, i_last_word);
    end

    // result words are checked on their strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_word(o_result_word, o_result_last, o_error_flag);
    end

    // drive one item and wait until it is taken
    task automatic send_item(logic [63:0] b, logic [63:0] e, logic [63:0] m, logic last);
        if (gaps_on && $urandom_range(99) < 37) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_base_word <= b;
        i_exponent_word <= e;
        i_modulus_word <= m;
        i_last_word <= last;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random operation of one or two words with varied operand shapes
    task automatic send_random_op();
        int n;
        logic [63:0] b, e, m;
        n = ($urandom_range(9) == 0) ? 2 : 1;
        for (int i = 0; i < n; i++) begin
            b = rand64();
            e = ($urandom_range(3) == 0) ? 64'($urandom_range(0, 300)) : rand64();
            case ($urandom_range(9))
                0: m = 64'($urandom_range(0, 2));
                1, 2: m = 64'($urandom_range(3, 1000));
                default: m = rand64();
            endcase
            send_item(b, e, m, i == n - 1);
        end
    endtask

    initial begin
        sb = new();
        gaps_on = 1'b0;
        items_sent = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_base_word = '0;
        i_exponent_word = '0;
        i_modulus_word = '0;
        i_last_word = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes and corner cases, one word each
        send_item('1, '1, '1, 1'b1);
        send_item('0, 64'd12345, 64'd1000003, 1'b1);
        send_item(64'd7, '0, 64'd13, 1'b1);
        send_item(64'd7, '0, 64'd1, 1'b1);
        send_item(64'd9, 64'd5, '0, 1'b1);
        send_item(64'hffff_0000_ffff_0000, 64'd3, 64'd97, 1'b1);
        send_item(64'd2, 64'd10, 64'd1 << 63, 1'b1);
        // two words, short high modulus word
        send_item('1, '1, '1, 1'b0);
        send_item('1, 64'd1, 64'd5, 1'b1);
        // overlong load saturates the store; zero modulus keeps the run short
        for (int i = 0; i < mee_pkg::WORDS + 2; i++)
            send_item(rand64(), rand64(), '0, i == mee_pkg::WORDS + 1);

        // random operations, with a stretch of back-to-back items in the middle
        gaps_on = 1'b1;
        while (items_sent < 100) begin
            gaps_on = !(items_sent > 60 && items_sent < 80);
            send_random_op();
        end
        start <= 1'b0;

        // drain
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("ran %0d operations (%0d with zero modulus), %0d result words checked",
                 sb.ops_done, sb.error_ops, sb.words_checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
